>>> sv/bmp_pixel_row_decoder_assert.svh
// ----------------------------------------------------------------------------
// Bitmap row decoder assertion macros
// Property shorthands used by the checker: same-cycle and next-cycle forms.
// ----------------------------------------------------------------------------
`ifndef BMP_PIXEL_ROW_DECODER_ASSERT_SVH
`define BMP_PIXEL_ROW_DECODER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define BPR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define BPR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bpr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap row decoder package
// Register indexes, field widths, queue entry types and the 565 scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package bpr_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BITS_PER_PIXEL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_STRIDE    = 2'd3;

   localparam int DIM_W      = 13;
   localparam int BPP_W      = 6;
   localparam int STRIDE_W   = 14;
   localparam int BYTE_CNT_W = 15;  // bytes in a row, also bounds the column count
   localparam int CALC_W     = 16;  // compare width for counts plus one
   localparam int COL_OUT_W  = 12;
   localparam int ROW_OUT_W  = 12;
   localparam int ADDR_W     = 25;
   localparam int TEXEL_W    = 32;
   localparam int GATHER_W   = 24;

   localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
   localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
   localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

   localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd1;
   localparam logic [DIM_W-1:0]    HEIGHT_RESET = 13'd1;
   localparam logic [BPP_W-1:0]    BPP_RESET    = 6'd32;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd4096;

   // pixel formats carried down the queue
   localparam logic [1:0] FMT_RGB565   = 2'd0;
   localparam logic [1:0] FMT_RGB888   = 2'd1;
   localparam logic [1:0] FMT_ARGB8888 = 2'd2;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // f*255/31 = 8f + floor(7f/31); the second term steps at these values of f
   localparam logic [4:0] SCALE5_STEP [7] = '{5'd5, 5'd9, 5'd14, 5'd18, 5'd23, 5'd27, 5'd31};
   // f*255/63 = 4f + floor(f/21)
   localparam logic [5:0] SCALE6_STEP [3] = '{6'd21, 6'd42, 6'd63};

   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [BPP_W-1:0]    bpp;
      logic [STRIDE_W-1:0] stride;
   } bpr_cfg_type;

   // one complete pixel, front to back
   typedef struct packed {
      logic [TEXEL_W-1:0]    bytes;
      logic [1:0]            fmt;
      logic [BYTE_CNT_W-1:0] column;
      logic [DIM_W-1:0]      dest_row;
      logic                  last;
   } bpr_pix_type;

   typedef struct packed {
      logic [TEXEL_W-1:0]   texel;
      logic [COL_OUT_W-1:0] column;
      logic [ROW_OUT_W-1:0] row;
      logic [ADDR_W-1:0]    word_address;
      logic                 last_texel;
   } bpr_rsp_type;

   function automatic logic [7:0] scale5(input logic [4:0] f);
      logic [2:0] q;
      q = 3'd0;
      for (int k = 0; k < 7; k++) begin
         if (f >= SCALE5_STEP[k]) q = q + 3'd1;
      end
      return {f, 3'b000} + {5'd0, q};
   endfunction

   function automatic logic [7:0] scale6(input logic [5:0] f);
      logic [1:0] q;
      q = 2'd0;
      for (int k = 0; k < 3; k++) begin
         if (f >= SCALE6_STEP[k]) q = q + 2'd1;
      end
      return {f, 2'b00} + {6'd0, q};
   endfunction

   // bytes: first stored byte in bits 7..0, next in 15..8 and so on
   function automatic logic [TEXEL_W-1:0] make_texel(input logic [1:0] fmt,
                                                    input logic [TEXEL_W-1:0] bytes);
      logic [7:0]  b0, b1, b2, b3;
      logic [15:0] v;
      b0 = bytes[7:0];
      b1 = bytes[15:8];
      b2 = bytes[23:16];
      b3 = bytes[31:24];
      v  = {b1, b0};
      case (fmt)
         FMT_ARGB8888: return {b3, b0, b1, b2};
         FMT_RGB888:   return {ALPHA_OPAQUE, b0, b1, b2};
         FMT_RGB565:   return {ALPHA_OPAQUE, scale5(v[4:0]), scale6(v[10:5]),
                               scale5(v[15:11])};
         default:      return '0;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> sv/bpr_fifo.sv
// ----------------------------------------------------------------------------
// Bitmap row decoder queue
// Small register queue with pointer wrap and a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> sv/bpr_front.sv
// ----------------------------------------------------------------------------
// Bitmap row decoder front end
// Counts bytes, pixels and rows, gathers pixel bytes, drops padding.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_front
   import bpr_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire bpr_cfg_type cfg,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   output logic             pix_valid,
   output bpr_pix_type      pix
);

   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [BYTE_CNT_W-1:0] bir_ff, bir_in;       // byte in row
   logic [1:0]            bip_ff, bip_in;       // byte in pixel
   logic [GATHER_W-1:0]   gather_ff, gather_in;
   logic [BYTE_CNT_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]      src_ff, src_in;       // source row, bottom first

   logic                  depth_ok;
   logic [1:0]            fmt;
   logic                  pix_last;
   logic [DIM_W-1:0]      width_c, height_c;
   logic [CALC_W-1:0]     pix_bytes, row_len;
   logic [ROW_W-1:0]      src_eff, src_next;
   logic [CALC_W-1:0]     src_inc, bir_inc, col_inc;
   logic [DIM_W-1:0]      dest_row;
   logic                  in_pix, row_end;
   logic [TEXEL_W-1:0]    bytes;

   always_comb begin
      depth_ok = 1'b1;
      fmt      = FMT_ARGB8888;
      unique case (cfg.bpp)
         BPP_32:  fmt = FMT_ARGB8888;
         BPP_24:  fmt = FMT_RGB888;
         BPP_16:  fmt = FMT_RGB565;
         default: depth_ok = 1'b0;
      endcase
   end

   // size registers clamped to 1..max
   always_comb begin
      width_c = cfg.width;
      if (cfg.width == '0) width_c = DIM_W'(1);
      else if (32'(cfg.width) > MAX_WIDTH) width_c = DIM_W'(MAX_WIDTH);
      height_c = cfg.height;
      if (cfg.height == '0) height_c = DIM_W'(1);
      else if (32'(cfg.height) > MAX_HEIGHT) height_c = DIM_W'(MAX_HEIGHT);
   end

   always_comb begin
      case (fmt)
         FMT_RGB565: begin
            pix_bytes = CALC_W'(width_c) << 1;
            pix_last  = (bip_ff >= 2'd1);
         end
         FMT_RGB888: begin
            pix_bytes = (CALC_W'(width_c) << 1) + CALC_W'(width_c);
            pix_last  = (bip_ff >= 2'd2);
         end
         default: begin
            pix_bytes = CALC_W'(width_c) << 2;
            pix_last  = (bip_ff == 2'd3);
         end
      endcase
      row_len = (pix_bytes + CALC_W'(3)) & ~CALC_W'(3);
   end

   assign src_eff  = (CALC_W'(src_ff) >= CALC_W'(height_c)) ? '0 : src_ff;
   assign src_inc  = CALC_W'(src_eff) + CALC_W'(1);
   assign src_next = (src_inc >= CALC_W'(height_c)) ? '0 : ROW_W'(src_inc);
   assign dest_row = height_c - DIM_W'(1) - DIM_W'(src_eff);
   assign bir_inc  = CALC_W'(bir_ff) + CALC_W'(1);
   assign col_inc  = CALC_W'(col_ff) + CALC_W'(1);
   assign in_pix   = (CALC_W'(bir_ff) < pix_bytes);
   assign row_end  = (bir_inc >= row_len);
   assign bytes    = {8'd0, gather_ff} | (TEXEL_W'(data_byte) << {bip_ff, 3'b000});

   always_comb begin
      bir_in    = bir_ff;
      bip_in    = bip_ff;
      gather_in = gather_ff;
      col_in    = col_ff;
      src_in    = src_ff;
      if (accept && depth_ok) begin
         src_in = src_eff;
         if (in_pix) begin
            if (pix_last) begin
               col_in    = BYTE_CNT_W'(col_inc);
               bip_in    = 2'd0;
               gather_in = '0;
            end else begin
               gather_in = bytes[GATHER_W-1:0];
               bip_in    = bip_ff + 2'd1;
            end
         end
         bir_in = BYTE_CNT_W'(bir_inc);
         if (row_end) begin
            bir_in    = '0;
            bip_in    = 2'd0;
            gather_in = '0;
            col_in    = '0;
            src_in    = src_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bir_ff    <= '0;
         bip_ff    <= 2'd0;
         gather_ff <= '0;
         col_ff    <= '0;
         src_ff    <= '0;
      end else begin
         bir_ff    <= bir_in;
         bip_ff    <= bip_in;
         gather_ff <= gather_in;
         col_ff    <= col_in;
         src_ff    <= src_in;
      end
   end

   assign pix_valid    = accept && depth_ok && in_pix && pix_last;
   assign pix.bytes    = bytes;
   assign pix.fmt      = fmt;
   assign pix.column   = col_ff;
   assign pix.dest_row = dest_row;
   assign pix.last     = (col_inc >= CALC_W'(width_c)) && (src_inc >= CALC_W'(height_c));

endmodule

`default_nettype wire

>>> sv/bpr_back.sv
// ----------------------------------------------------------------------------
// Bitmap row decoder back end
// Converts a pixel to a texel and forms its destination word address.
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_back
   import bpr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [STRIDE_W-1:0] stride,
   input  wire logic                pix_avail,
   input  wire bpr_pix_type         pix,
   output logic                     pix_pop,
   output logic                     rsp_push,
   output bpr_rsp_type              rsp,
   input  wire logic                rsp_full
);

   localparam int PROD_W = DIM_W + STRIDE_W;

   logic                  s1_valid_ff, s1_valid_in;
   logic [TEXEL_W-1:0]    texel_ff;
   logic [ADDR_W-1:0]     base_ff;       // dest_row * stride, low bits
   logic [BYTE_CNT_W-1:0] column_ff;
   logic [ROW_OUT_W-1:0]  row_ff;
   logic                  last_ff;
   logic [PROD_W-1:0]     product;
   logic                  s1_adv;

   assign product  = PROD_W'(pix.dest_row) * PROD_W'(stride);
   assign s1_adv   = s1_valid_ff && !rsp_full;
   assign pix_pop  = pix_avail && (!s1_valid_ff || !rsp_full);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pix_pop) s1_valid_in = 1'b1;
      else if (s1_adv) s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_pop) begin
         texel_ff  <= make_texel(pix.fmt, pix.bytes);
         base_ff   <= product[ADDR_W-1:0];
         column_ff <= pix.column;
         row_ff    <= pix.dest_row[ROW_OUT_W-1:0];
         last_ff   <= pix.last;
      end
   end

   assign rsp_push         = s1_adv;
   assign rsp.texel        = texel_ff;
   assign rsp.column       = column_ff[COL_OUT_W-1:0];
   assign rsp.row          = row_ff;
   assign rsp.word_address = base_ff + ADDR_W'(column_ff);
   assign rsp.last_texel   = last_ff;

endmodule

`default_nettype wire

>>> sv/bmp_pixel_row_decoder.sv
// A texel passes from the pixel queue through the back end register stage and the result queue to the rsp_ ports.
// Throughput: one byte per cycle while req_full is low; the byte counters in the front end close each step.
// req_full rises only when the four-entry pixel queue is full (result side stalled).
// Reset (synchronous, active high) clears counters and queues and loads the registers
// with width 1, height 1, 32 bits per pixel, stride 4096; no clearing pass.
// ----------------------------------------------------------------------------
// Bitmap pixel row decoder
// Turns the pixel-data bytes of an uncompressed bitmap (16, 24 or 32 bits per
// pixel, rows padded to four bytes, bottom row first) into 32-bit texels with
// column, flipped row and destination word address.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_row_decoder
   import bpr_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // byte input, queue style
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire logic [7:0]             req_data_byte,
   // texel output, queue style
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [TEXEL_W-1:0]          rsp_texel,
   output logic [COL_OUT_W-1:0]        rsp_column,
   output logic [ROW_OUT_W-1:0]        rsp_row,
   output logic [ADDR_W-1:0]           rsp_word_address,
   output logic                        rsp_last_texel,
   // register writes
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PIX_Q_DEPTH = 4;
   localparam int RSP_Q_DEPTH = 2;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   logic [BPP_W-1:0]    bpp_ff, bpp_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   bpr_cfg_type         cfg;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      stride_in = stride_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    width_in  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:   height_in = csr_wdata[DIM_W-1:0];
            CSR_BITS_PER_PIXEL: bpp_in    = csr_wdata[BPP_W-1:0];
            CSR_DEST_STRIDE:    stride_in = csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         bpp_ff    <= BPP_RESET;
         stride_ff <= STRIDE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         stride_ff <= stride_in;
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;
   assign cfg.bpp    = bpp_ff;
   assign cfg.stride = stride_ff;

   // ------------------------------------------------------------------
   // Front end: with a supported depth, every accepted byte updates the counters;
   // the last byte of a pixel pushes one entry into the pixel queue.
   // Padding bytes and unsupported depths push nothing.
   // ------------------------------------------------------------------
   logic        accept;
   logic        front_valid;
   bpr_pix_type front_pix;
   logic        pix_q_full, pix_q_empty, pix_q_pop;
   logic [$bits(bpr_pix_type)-1:0] pix_q_rdata;
   bpr_pix_type pix_q_head;

   // at most one entry per byte, so a free slot is all the front needs
   assign accept = req_push && !req_full;
   assign req_full = pix_q_full;

   bpr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .data_byte (req_data_byte),
      .pix_valid (front_valid),
      .pix       (front_pix)
   );

   bpr_fifo #(
      .WIDTH ($bits(bpr_pix_type)),
      .DEPTH (PIX_Q_DEPTH)
   ) u_pix_q (
      .clock (clock),
      .reset (reset),
      .push  (front_valid),
      .wdata (front_pix),
      .full  (pix_q_full),
      .pop   (pix_q_pop),
      .rdata (pix_q_rdata),
      .empty (pix_q_empty)
   );

   assign pix_q_head = bpr_pix_type'(pix_q_rdata);

   // ------------------------------------------------------------------
   // Back end: one register stage holds the converted texel and the
   // row base product; the column add lands in the result queue.
   // The user must keep stride stable whenever items are in flight; the block does not enforce it.
   // ------------------------------------------------------------------
   logic        rsp_q_push, rsp_q_full;
   bpr_rsp_type back_rsp;
   logic [$bits(bpr_rsp_type)-1:0] rsp_q_rdata;
   bpr_rsp_type rsp_head;

   bpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stride    (stride_ff),
      .pix_avail (!pix_q_empty),
      .pix       (pix_q_head),
      .pix_pop   (pix_q_pop),
      .rsp_push  (rsp_q_push),
      .rsp       (back_rsp),
      .rsp_full  (rsp_q_full)
   );

   // two entries decouple the consumer from the back end stage
   bpr_fifo #(
      .WIDTH ($bits(bpr_rsp_type)),
      .DEPTH (RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_q_push),
      .wdata (back_rsp),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .rdata (rsp_q_rdata),
      .empty (rsp_empty)
   );

   assign rsp_head         = bpr_rsp_type'(rsp_q_rdata);
   assign rsp_texel        = rsp_head.texel;
   assign rsp_column       = rsp_head.column;
   assign rsp_row          = rsp_head.row;
   assign rsp_word_address = rsp_head.word_address;
   assign rsp_last_texel   = rsp_head.last_texel;

endmodule

`default_nettype wire

>>> sv/bpr_checker.sv
// ----------------------------------------------------------------------------
// Bitmap row decoder checker
// Port-level properties of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp_pixel_row_decoder_assert.svh"

module bpr_checker
   import bpr_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_full,
   input wire logic                   rsp_empty,
   input wire logic                   rsp_pop,
   input wire logic [TEXEL_W-1:0]     rsp_texel,
   input wire logic [ROW_OUT_W-1:0]   rsp_row,
   input wire logic                   rsp_last_texel,
   input wire logic                   csr_we,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [BPP_W-1:0]     bpp_seen_ff, bpp_seen_in;
   logic [TEXEL_W-1:0]   texel_seen_ff;   // registered copy of the result ports
   logic [ROW_OUT_W-1:0] row_seen_ff;
   logic                 rsp_wait;
   logic                 idle_ok, hold_ok;
   logic                 last_due, last_ok;
   logic                 alpha_due, alpha_ok;

   always_comb begin
      bpp_seen_in = bpp_seen_ff;
      if (csr_we && (csr_index == CSR_BITS_PER_PIXEL)) bpp_seen_in = csr_wdata[BPP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_seen_ff <= BPP_RESET;
      end else begin
         bpp_seen_ff <= bpp_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      texel_seen_ff <= rsp_texel;
      row_seen_ff   <= rsp_row;
   end

   assign rsp_wait  = !rsp_empty && !rsp_pop;
   assign idle_ok   = rsp_empty && !req_full;
   assign hold_ok   = !rsp_empty && (rsp_texel == texel_seen_ff) && (rsp_row == row_seen_ff);
   assign last_due  = !rsp_empty && rsp_last_texel;
   assign last_ok   = (rsp_row == '0);
   assign alpha_due = !rsp_empty && (bpp_seen_ff != BPP_32);
   assign alpha_ok  = (rsp_texel[31:24] == ALPHA_OPAQUE);

   // queues come out of reset empty and ready for bytes
   `BPR_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, idle_ok, "queues not cleared by reset")
   // a waiting item stays put
   `BPR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_wait, hold_ok, "waiting item changed")
   // the last texel of an image is the top destination row
   `BPR_ASSERT_IMP(a_last_row, clock, reset, last_due, last_ok, "last texel not on row zero")
   // 16- and 24-bit pixels are opaque
   `BPR_ASSERT_IMP(a_alpha, clock, reset, alpha_due, alpha_ok, "alpha not opaque")

endmodule

bind bmp_pixel_row_decoder bpr_checker u_bpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_texel      (rsp_texel),
   .rsp_row        (rsp_row),
   .rsp_last_texel (rsp_last_texel),
   .csr_we         (csr_we),
   .csr_index      (csr_index),
   .csr_wdata      (csr_wdata)
);

`default_nettype wire
